>>> rtl/skfr_pkg.sv
// Shared types and codes for the string key frequency rank core.
`default_nettype none
package skfr_pkg;

   localparam int TableEntriesDefault = 32;
   localparam int KeySlotBytesDefault = 50;
   localparam int CountBitsDefault    = 16;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_END  = 2'd1,
      KIND_RPT  = 2'd2,
      KIND_READ = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RK_STATUS = 2'd0,
      RK_REPORT = 2'd1,
      RK_CHAR   = 2'd2,
      RK_SPARE  = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      ST_NEW   = 2'd0,
      ST_HIT   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      EM_HIT    = 3'd0,
      EM_NEW    = 3'd1,
      EM_FULL   = 3'd2,
      EM_EMPTY  = 3'd3,
      EM_RPT    = 3'd4,
      EM_RDMISS = 3'd5,
      EM_RDHIT  = 3'd6,
      EM_SPARE  = 3'd7
   } emit_sel_type;

   typedef enum logic [1:0] {
      RS_A    = 2'd0,
      RS_B    = 2'd1,
      RS_SLOT = 2'd2,
      RS_NONE = 2'd3
   } rec_sel_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_code;
      logic [4:0] slot;
      logic [5:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [1:0]  status;
      logic [4:0]  entry_slot;
      logic [15:0] occurrences;
      logic [5:0]  key_length;
      logic [7:0]  stored_char;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic         accept;
      logic         rec_rd;
      rec_sel_type  rec_sel;
      logic         a_inc;
      logic         a_clr;
      logic         b_load;
      logic         b_inc;
      logic         k_clr;
      logic         k_inc;
      logic         pair_rd;
      logic         chr_rd;
      logic         cp_wr;
      logic         ldi;
      logic         sel_upd;
      logic         sw1;
      logic         sw2;
      logic         emit;
      emit_sel_type emit_sel;
   } cmd_type;

   typedef struct packed {
      logic a_lt_n;
      logic a1_lt_n;
      logic b_lt_n;
      logic k_lt_len;
      logic len_match;
      logic chars_eq;
      logic used_zero;
      logic room;
      logic slot_ok;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

>>> rtl/skfr_ctrl.sv
// Sequencing state machine for the string key frequency rank core.
`default_nettype none
module skfr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_kind,
   output logic                  req_ready,
   input  wire skfr_pkg::sts_type sts,
   output skfr_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      S_IDLE, E_REC, E_RECW, E_CMPRD, E_CMPCHK, E_HIT, E_NEW, E_CPRD, E_CPWR, E_FIN,
      R_START, S_OUTER, S_LDI, S_INNER, S_CMP, S_SW1, S_SW2, P_RD, P_EMIT,
      RD_REC, RD_CHR, RD_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.rec_sel  = skfr_pkg::RS_NONE;
      cmd.emit_sel = skfr_pkg::EM_SPARE;
      state_in     = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (skfr_pkg::kind_type'(req_kind))
                  skfr_pkg::KIND_CHAR: state_in = S_IDLE;
                  skfr_pkg::KIND_END:  state_in = E_REC;
                  skfr_pkg::KIND_RPT:  state_in = R_START;
                  skfr_pkg::KIND_READ: state_in = RD_REC;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         E_REC: begin
            if (sts.a_lt_n) begin
               cmd.rec_rd  = 1'b1;
               cmd.rec_sel = skfr_pkg::RS_A;
               state_in    = E_RECW;
            end else begin
               state_in = E_NEW;
            end
         end
         E_RECW: begin
            if (sts.len_match) begin
               cmd.k_clr = 1'b1;
               state_in  = E_CMPRD;
            end else begin
               cmd.a_inc = 1'b1;
               state_in  = E_REC;
            end
         end
         E_CMPRD: begin
            if (sts.k_lt_len) begin
               cmd.pair_rd = 1'b1;
               cmd.k_inc   = 1'b1;
               state_in    = E_CMPCHK;
            end else begin
               state_in = E_HIT;
            end
         end
         E_CMPCHK: begin
            if (sts.chars_eq) begin
               state_in = E_CMPRD;
            end else begin
               cmd.a_inc = 1'b1;
               state_in  = E_REC;
            end
         end
         E_HIT: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = skfr_pkg::EM_HIT;
               state_in     = S_IDLE;
            end
         end
         E_NEW: begin
            if (sts.room) begin
               cmd.k_clr = 1'b1;
               state_in  = E_CPRD;
            end else if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = skfr_pkg::EM_FULL;
               state_in     = S_IDLE;
            end
         end
         E_CPRD: begin
            if (sts.k_lt_len) begin
               cmd.pair_rd = 1'b1;
               state_in    = E_CPWR;
            end else begin
               state_in = E_FIN;
            end
         end
         E_CPWR: begin
            cmd.cp_wr = 1'b1;
            cmd.k_inc = 1'b1;
            state_in  = E_CPRD;
         end
         E_FIN: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = skfr_pkg::EM_NEW;
               state_in     = S_IDLE;
            end
         end
         R_START: begin
            if (!sts.used_zero) begin
               state_in = S_OUTER;
            end else if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = skfr_pkg::EM_EMPTY;
               state_in     = S_IDLE;
            end
         end
         S_OUTER: begin
            if (sts.a1_lt_n) begin
               cmd.rec_rd  = 1'b1;
               cmd.rec_sel = skfr_pkg::RS_A;
               cmd.b_load  = 1'b1;
               state_in    = S_LDI;
            end else begin
               cmd.a_clr = 1'b1;
               state_in  = P_RD;
            end
         end
         S_LDI: begin
            cmd.ldi  = 1'b1;
            state_in = S_INNER;
         end
         S_INNER: begin
            if (sts.b_lt_n) begin
               cmd.rec_rd  = 1'b1;
               cmd.rec_sel = skfr_pkg::RS_B;
               state_in    = S_CMP;
            end else begin
               state_in = S_SW1;
            end
         end
         S_CMP: begin
            cmd.sel_upd = 1'b1;
            cmd.b_inc   = 1'b1;
            state_in    = S_INNER;
         end
         S_SW1: begin
            cmd.sw1  = 1'b1;
            state_in = S_SW2;
         end
         S_SW2: begin
            cmd.sw2   = 1'b1;
            cmd.a_inc = 1'b1;
            state_in  = S_OUTER;
         end
         P_RD: begin
            cmd.rec_rd  = 1'b1;
            cmd.rec_sel = skfr_pkg::RS_A;
            state_in    = P_EMIT;
         end
         P_EMIT: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = skfr_pkg::EM_RPT;
               cmd.a_inc    = 1'b1;
               state_in     = sts.a1_lt_n ? P_RD : S_IDLE;
            end
         end
         RD_REC: begin
            if (sts.slot_ok) begin
               cmd.rec_rd  = 1'b1;
               cmd.rec_sel = skfr_pkg::RS_SLOT;
               state_in    = RD_CHR;
            end else if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = skfr_pkg::EM_RDMISS;
               state_in     = S_IDLE;
            end
         end
         RD_CHR: begin
            cmd.chr_rd = 1'b1;
            state_in   = RD_EMIT;
         end
         RD_EMIT: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = skfr_pkg::EM_RDHIT;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/skfr_dp.sv
// Storage, counters and result register for the string key frequency rank core.
`default_nettype none
module skfr_dp #(
   parameter int TABLE_ENTRIES  = skfr_pkg::TableEntriesDefault,
   parameter int KEY_SLOT_BYTES = skfr_pkg::KeySlotBytesDefault,
   parameter int COUNT_BITS     = skfr_pkg::CountBitsDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire skfr_pkg::req_type req_payload,
   input  wire skfr_pkg::cmd_type cmd,
   output skfr_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output skfr_pkg::rsp_type      rsp_payload
);

   localparam int KeyMax = KEY_SLOT_BYTES - 1;
   localparam int SW     = $clog2(TABLE_ENTRIES);
   localparam int NW     = $clog2(TABLE_ENTRIES + 1);
   localparam int LW     = $clog2(KEY_SLOT_BYTES);
   localparam int KW     = (KeyMax > 1) ? $clog2(KeyMax) : 1;
   localparam int CharDepth = TABLE_ENTRIES * (2 ** KW);

   typedef struct packed {
      logic [SW-1:0]         phys;
      logic [LW-1:0]         len;
      logic [COUNT_BITS-1:0] cnt;
   } rec_type;

   rec_type    rec_mem [TABLE_ENTRIES];
   logic [7:0] char_mem [CharDepth];
   logic [7:0] pend_mem [KeyMax];

   logic [NW-1:0] used_ff, used_in;
   logic [LW-1:0] plen_ff, plen_in;
   logic [LW-1:0] klen_ff, klen_in;
   logic [NW-1:0] a_ff, a_in;
   logic [NW-1:0] b_ff, b_in;
   logic [LW-1:0] k_ff, k_in;
   logic [SW-1:0] best_ff, best_in;
   rec_type       best_rec_ff, best_rec_in;
   rec_type       irec_ff, irec_in;
   rec_type       rec_rd_ff;
   logic [7:0]    pend_rd_ff;
   logic [7:0]    char_rd_ff;
   logic [4:0]    slot_ff;
   logic [5:0]    pos_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   skfr_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW-1:0]         rec_rd_addr;
   logic                  rec_wr;
   logic [SW-1:0]         rec_wr_addr;
   rec_type               rec_wr_data;
   logic [COUNT_BITS-1:0] cnt_next;
   logic [SW+KW-1:0]      char_rd_addr;
   logic                  push;

   assign push = cmd.accept && (skfr_pkg::kind_type'(req_payload.kind) == skfr_pkg::KIND_CHAR)
                 && (32'(plen_ff) < KeyMax);

   always_comb begin
      sts.a_lt_n    = (a_ff < used_ff);
      sts.a1_lt_n   = ((33'(a_ff) + 33'd1) < 33'(used_ff));
      sts.b_lt_n    = (b_ff < used_ff);
      sts.k_lt_len  = (k_ff < klen_ff);
      sts.len_match = (rec_rd_ff.len == klen_ff);
      sts.chars_eq  = (pend_rd_ff == char_rd_ff);
      sts.used_zero = (used_ff == '0);
      sts.room      = (32'(used_ff) < TABLE_ENTRIES);
      sts.slot_ok   = (32'(slot_ff) < 32'(used_ff));
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign cnt_next = (rec_rd_ff.cnt == '1) ? rec_rd_ff.cnt : rec_rd_ff.cnt + 1'b1;

   always_comb begin
      priority case (1'b1)
         (cmd.rec_sel == skfr_pkg::RS_B):    rec_rd_addr = b_ff[SW-1:0];
         (cmd.rec_sel == skfr_pkg::RS_SLOT): rec_rd_addr = SW'(slot_ff);
         default:                            rec_rd_addr = a_ff[SW-1:0];
      endcase
   end

   // one write port: count update, new entry, or either half of a swap
   always_comb begin
      rec_wr      = 1'b0;
      rec_wr_addr = a_ff[SW-1:0];
      rec_wr_data = rec_rd_ff;
      if (cmd.emit && cmd.emit_sel == skfr_pkg::EM_HIT) begin
         rec_wr           = 1'b1;
         rec_wr_data.cnt  = cnt_next;
      end else if (cmd.emit && cmd.emit_sel == skfr_pkg::EM_NEW) begin
         rec_wr           = 1'b1;
         rec_wr_addr      = used_ff[SW-1:0];
         rec_wr_data.phys = used_ff[SW-1:0];
         rec_wr_data.len  = klen_ff;
         rec_wr_data.cnt  = COUNT_BITS'(1);
      end else if (cmd.sw1) begin
         rec_wr      = 1'b1;
         rec_wr_data = best_rec_ff;
      end else if (cmd.sw2) begin
         rec_wr      = 1'b1;
         rec_wr_addr = best_ff;
         rec_wr_data = irec_ff;
      end
   end

   assign char_rd_addr = cmd.chr_rd ? {rec_rd_ff.phys, KW'(pos_ff)}
                                    : {rec_rd_ff.phys, k_ff[KW-1:0]};

   always_ff @(posedge clock) begin
      if (rec_wr) begin
         rec_mem[rec_wr_addr] <= rec_wr_data;
      end
      if (cmd.rec_rd) begin
         rec_rd_ff <= rec_mem[rec_rd_addr];
      end
      if (push) begin
         pend_mem[plen_ff[KW-1:0]] <= req_payload.char_code;
      end
      if (cmd.pair_rd) begin
         pend_rd_ff <= pend_mem[k_ff[KW-1:0]];
      end
      if (cmd.cp_wr) begin
         char_mem[{used_ff[SW-1:0], k_ff[KW-1:0]}] <= pend_rd_ff;
      end
      if (cmd.pair_rd || cmd.chr_rd) begin
         char_rd_ff <= char_mem[char_rd_addr];
      end
   end

   always_comb begin
      used_in     = used_ff;
      plen_in     = plen_ff;
      klen_in     = klen_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      k_in        = k_ff;
      best_in     = best_ff;
      best_rec_in = best_rec_ff;
      irec_in     = irec_ff;
      if (cmd.accept) begin
         a_in = '0;
         if (skfr_pkg::kind_type'(req_payload.kind) == skfr_pkg::KIND_END) begin
            klen_in = plen_ff;
            plen_in = '0;
         end
      end
      if (push) begin
         plen_in = plen_ff + 1'b1;
      end
      if (cmd.a_clr) begin
         a_in = '0;
      end
      if (cmd.a_inc) begin
         a_in = a_ff + 1'b1;
      end
      if (cmd.b_load) begin
         b_in = a_ff + 1'b1;
      end
      if (cmd.b_inc) begin
         b_in = b_ff + 1'b1;
      end
      if (cmd.k_clr) begin
         k_in = '0;
      end
      if (cmd.k_inc) begin
         k_in = k_ff + 1'b1;
      end
      if (cmd.ldi) begin
         irec_in     = rec_rd_ff;
         best_rec_in = rec_rd_ff;
         best_in     = a_ff[SW-1:0];
      end
      if (cmd.sel_upd && (best_rec_ff.cnt < rec_rd_ff.cnt)) begin
         best_rec_in = rec_rd_ff;
         best_in     = b_ff[SW-1:0];
      end
      if (cmd.emit && cmd.emit_sel == skfr_pkg::EM_NEW) begin
         used_in = used_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in       = '0;
      rsp_in.last  = 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.emit_sel)
            skfr_pkg::EM_HIT: begin
               rsp_in.result_kind = skfr_pkg::RK_STATUS;
               rsp_in.status      = skfr_pkg::ST_HIT;
               rsp_in.entry_slot  = 5'(a_ff);
               rsp_in.occurrences = 16'(cnt_next);
               rsp_in.key_length  = 6'(klen_ff);
            end
            skfr_pkg::EM_NEW: begin
               rsp_in.result_kind = skfr_pkg::RK_STATUS;
               rsp_in.status      = skfr_pkg::ST_NEW;
               rsp_in.entry_slot  = 5'(used_ff);
               rsp_in.occurrences = 16'd1;
               rsp_in.key_length  = 6'(klen_ff);
            end
            skfr_pkg::EM_FULL: begin
               rsp_in.result_kind = skfr_pkg::RK_STATUS;
               rsp_in.status      = skfr_pkg::ST_FULL;
            end
            skfr_pkg::EM_EMPTY: begin
               rsp_in.result_kind = skfr_pkg::RK_REPORT;
               rsp_in.status      = skfr_pkg::ST_EMPTY;
            end
            skfr_pkg::EM_RPT: begin
               rsp_in.result_kind = skfr_pkg::RK_REPORT;
               rsp_in.status      = skfr_pkg::ST_NEW;
               rsp_in.entry_slot  = 5'(a_ff);
               rsp_in.occurrences = 16'(rec_rd_ff.cnt);
               rsp_in.key_length  = 6'(rec_rd_ff.len);
               rsp_in.last        = !sts.a1_lt_n;
            end
            skfr_pkg::EM_RDMISS: begin
               rsp_in.result_kind = skfr_pkg::RK_CHAR;
               rsp_in.entry_slot  = slot_ff;
            end
            skfr_pkg::EM_RDHIT: begin
               rsp_in.result_kind = skfr_pkg::RK_CHAR;
               rsp_in.entry_slot  = slot_ff;
               rsp_in.occurrences = 16'(rec_rd_ff.cnt);
               rsp_in.key_length  = 6'(rec_rd_ff.len);
               rsp_in.stored_char = (32'(pos_ff) < 32'(rec_rd_ff.len)) ? char_rd_ff : 8'd0;
            end
            default: rsp_in.last = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         plen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         plen_ff      <= plen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      klen_ff     <= klen_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      k_ff        <= k_in;
      best_ff     <= best_in;
      best_rec_ff <= best_rec_in;
      irec_ff     <= irec_in;
      if (cmd.accept) begin
         slot_ff <= req_payload.slot;
         pos_ff  <= req_payload.position;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= TABLE_ENTRIES) else $error("entry count beyond table size");
   a_plen_bound: assert property (@(posedge clock) disable iff (reset)
      32'(plen_ff) <= KeyMax) else $error("pending key length beyond buffer");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free) else $error("result loaded over an untaken result");
   a_new_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_sel == skfr_pkg::EM_NEW) |=> (used_ff == $past(used_ff) + 1'b1))
      else $error("new entry did not advance entry count");

endmodule
`default_nettype wire

>>> rtl/string_key_frequency_rank_core.sv
// A key character transfer gives no result.
// End of key: walk the used entries, comparing characters where lengths match, and
// copy the characters of a new entry; read: fetch one entry record and one stored
// character; report: selection sort over the entry table, one table read port.
// One item is worked at a time; the result register lets the next transfer in.
// Reset clears entry count and pending length; key and count storage is not swept.
`default_nettype none
module string_key_frequency_rank_core #(
   parameter int TABLE_ENTRIES  = skfr_pkg::TableEntriesDefault,
   parameter int KEY_SLOT_BYTES = skfr_pkg::KeySlotBytesDefault,
   parameter int COUNT_BITS     = skfr_pkg::CountBitsDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire skfr_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output skfr_pkg::rsp_type      rsp_payload
);

   // command and status between the sequencer and the storage datapath
   skfr_pkg::cmd_type cmd;
   skfr_pkg::sts_type sts;

   // sequencer: decode each transfer, walk entries, sort, drain the report, and answer reads
   skfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: pending key, key characters, entry records, result register
   skfr_dp #(
      .TABLE_ENTRIES  (TABLE_ENTRIES),
      .KEY_SLOT_BYTES (KEY_SLOT_BYTES),
      .COUNT_BITS     (COUNT_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
